FILE: design/plc_pkg.sv
// Shared types, codes and microcode table of the pairing list codec.
`timescale 1ns / 1ps

package plc_pkg;

   localparam int MAX_ATOMS_DEF = 7;
   localparam int CODE_BITS_DEF = 32;
   localparam int CNT_W         = 4;
   localparam int DEC_Z_W       = 29;

   localparam logic [1:0] KIND_CODE  = 2'd0;
   localparam logic [1:0] KIND_ATOM  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] CAUSE_NONE     = 2'd0;
   localparam logic [1:0] CAUSE_OVERFLOW = 2'd1;
   localparam logic [1:0] CAUSE_TOO_MANY = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_ATOM,
      OP_MUL,
      OP_FOLD,
      OP_EMIT_ENC,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_TRI,
      OP_PEEL,
      OP_EMIT_ATOM,
      OP_EMIT_LAST,
      OP_EMIT_EMPTY
   } dp_op_type;

   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_DECODE,
      CND_NO_ATOM,
      CND_NO_FOLD,
      CND_IT_MORE,
      CND_NOT_END,
      CND_SIZE_ZERO,
      CND_LAST_ELEM
   } cond_type;

   typedef enum logic [1:0] {
      WT_NONE,
      WT_REQ,
      WT_OUT
   } wait_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_E_CHK,
      S_E_ATOM,
      S_E_MUL,
      S_E_FOLD,
      S_E_END,
      S_E_EMIT,
      S_D_CHK,
      S_D_LOOP,
      S_D_SQ,
      S_D_TRI,
      S_D_PEEL,
      S_D_EMIT,
      S_D_LAST,
      S_D_EMPTY
   } step_type;

   typedef struct packed {
      dp_op_type op;
      wait_type  wait_on;
      cond_type  cond;
      step_type  target;
   } ucode_word_type;

   typedef struct packed {
      dp_op_type op;
      logic      en;
   } ctrl_type;

   typedef struct packed {
      logic decode;
      logic no_atom;
      logic no_fold;
      logic it_more;
      logic not_end;
      logic size_zero;
      logic last_elem;
      logic out_busy;
   } status_type;

   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      unique case (step)
         S_IDLE:    w = '{OP_LATCH,      WT_REQ,  CND_DECODE,    S_D_CHK};
         S_E_CHK:   w = '{OP_NOP,        WT_NONE, CND_NO_ATOM,   S_E_END};
         S_E_ATOM:  w = '{OP_ATOM,       WT_NONE, CND_NO_FOLD,   S_E_END};
         S_E_MUL:   w = '{OP_MUL,        WT_NONE, CND_IT_MORE,   S_E_MUL};
         S_E_FOLD:  w = '{OP_FOLD,       WT_NONE, CND_NEVER,     S_IDLE};
         S_E_END:   w = '{OP_NOP,        WT_NONE, CND_NOT_END,   S_IDLE};
         S_E_EMIT:  w = '{OP_EMIT_ENC,   WT_OUT,  CND_ALWAYS,    S_IDLE};
         S_D_CHK:   w = '{OP_NOP,        WT_NONE, CND_SIZE_ZERO, S_D_EMPTY};
         S_D_LOOP:  w = '{OP_SQ_INIT,    WT_NONE, CND_LAST_ELEM, S_D_LAST};
         S_D_SQ:    w = '{OP_SQ_STEP,    WT_NONE, CND_IT_MORE,   S_D_SQ};
         S_D_TRI:   w = '{OP_TRI,        WT_NONE, CND_NEVER,     S_IDLE};
         S_D_PEEL:  w = '{OP_PEEL,       WT_NONE, CND_NEVER,     S_IDLE};
         S_D_EMIT:  w = '{OP_EMIT_ATOM,  WT_OUT,  CND_ALWAYS,    S_D_LOOP};
         S_D_LAST:  w = '{OP_EMIT_LAST,  WT_OUT,  CND_ALWAYS,    S_IDLE};
         S_D_EMPTY: w = '{OP_EMIT_EMPTY, WT_OUT,  CND_ALWAYS,    S_IDLE};
         default:   w = '{OP_NOP,        WT_NONE, CND_ALWAYS,    S_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: design/plc_sequencer.sv
// Microcode sequencer: step counter, control table lookup and branch logic.
`timescale 1ns / 1ps

module plc_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  plc_pkg::status_type status,
   output plc_pkg::ctrl_type   ctrl,
   output logic               idle
);
   import plc_pkg::*;

   step_type       upc_ff;
   step_type       upc_in;
   ucode_word_type uw;
   logic           hold;
   logic           jump;

   always_comb begin
      uw   = ucode_rom(upc_ff);
      hold = ((uw.wait_on == WT_REQ) && !req_valid) ||
             ((uw.wait_on == WT_OUT) && status.out_busy);
      unique case (uw.cond)
         CND_NEVER:     jump = 1'b0;
         CND_ALWAYS:    jump = 1'b1;
         CND_DECODE:    jump = status.decode;
         CND_NO_ATOM:   jump = status.no_atom;
         CND_NO_FOLD:   jump = status.no_fold;
         CND_IT_MORE:   jump = status.it_more;
         CND_NOT_END:   jump = status.not_end;
         CND_SIZE_ZERO: jump = status.size_zero;
         CND_LAST_ELEM: jump = status.last_elem;
         default:       jump = 1'b1;
      endcase
      if (hold) begin
         upc_in = upc_ff;
      end else if (jump) begin
         upc_in = uw.target;
      end else begin
         upc_in = step_type'(upc_ff + 4'd1);
      end
      ctrl.op = uw.op;
      ctrl.en = !hold;
      idle    = (uw.wait_on == WT_REQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

FILE: design/plc_datapath.sv
// Codec datapath: list state, fold multiplier, square root unit, result register.
`timescale 1ns / 1ps

module plc_datapath #(
   parameter int MAX_ATOMS = plc_pkg::MAX_ATOMS_DEF,
   parameter int CODE_BITS = plc_pkg::CODE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  plc_pkg::ctrl_type    ctrl,
   output plc_pkg::status_type  status,
   input  logic                req_operation,
   input  logic [15:0]         req_atom_value,
   input  logic                req_has_atom,
   input  logic                req_list_end,
   input  logic [31:0]         req_packed_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [31:0]         rsp_value,
   output logic [1:0]          rsp_error_cause,
   output logic                rsp_last_result
);
   import plc_pkg::*;

   localparam int L      = CODE_BITS - 3;
   localparam int ITER_N = (L > 16) ? L : 16;
   localparam int SW     = ITER_N + 1;
   localparam int IT_W   = $clog2(ITER_N);
   localparam logic [L-1:0] LIMIT = '1;

   // list state
   logic [L-1:0]       code_ff, code_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   // latched request
   logic [15:0]        atom_ff, atom_in;
   logic               has_ff, has_in;
   logic               end_ff, end_in;
   // fold multiplier
   logic [L-1:0]       s_ff, s_in;
   logic [L-1:0]       sh_ff, sh_in;
   logic [L:0]         acc_ff, acc_in;
   logic               big_ff, big_in;
   logic [IT_W-1:0]    it_ff, it_in;
   // decode
   logic [DEC_Z_W-1:0] z_ff, z_in;
   logic [2:0]         n_ff, n_in;
   logic [31:0]        v_ff, v_in;
   logic [15:0]        r_ff, r_in;
   logic [17:0]        rem_ff, rem_in;
   logic [30:0]        prod_ff, prod_in;
   logic [15:0]        elem_ff, elem_in;
   // result register
   logic               rv_ff, rv_in;
   logic [1:0]         kind_ff, kind_in;
   logic [31:0]        val_ff, val_in;
   logic [1:0]         cause_ff, cause_in;
   logic               last_ff, last_in;

   logic [SW-1:0]      sum;
   logic               fold_go;
   logic [L+2:0]       mul_nxt;
   logic [L:0]         zsum;
   logic [19:0]        remc;
   logic [19:0]        trial;
   logic [15:0]        rdec;
   logic [14:0]        w;
   logic [15:0]        wp1;
   logic [29:0]        tri_w;
   logic [29:0]        xs;
   logic [CODE_BITS+31:0] enc_ext;
   logic               go;

   assign go      = ctrl.en;
   assign sum     = SW'(code_ff) + SW'(atom_ff);
   assign fold_go = (cnt_ff != '0) && (cnt_ff < CNT_W'(MAX_ATOMS)) && !ovf_ff &&
                    (sum <= SW'(LIMIT));
   assign mul_nxt = (L+3)'({acc_ff, 1'b0}) + (sh_ff[L-1] ? (L+3)'(s_ff) + (L+3)'(1) : '0);
   assign zsum    = (L+1)'(acc_ff[L:1]) + (L+1)'(code_ff);
   assign remc    = {rem_ff, v_ff[31:30]};
   assign trial   = {2'b00, r_ff, 2'b01};
   assign rdec    = r_ff - 16'd1;
   assign w       = rdec[15:1];
   assign wp1     = {1'b0, w} + 16'd1;
   assign tri_w   = prod_ff[30:1];
   assign xs      = 30'(z_ff) - tri_w;
   assign enc_ext = {32'd0, code_ff, cnt_ff[2:0]};

   always_comb begin
      // dispatch on the request being latched in the idle step
      status.decode    = req_operation;
      status.no_atom   = !has_ff;
      status.no_fold   = !fold_go;
      status.it_more   = (it_ff != '0);
      status.not_end   = !end_ff;
      status.size_zero = (n_ff == 3'd0);
      status.last_elem = (n_ff == 3'd1);
      status.out_busy  = rv_ff && rsp_stall;
   end

   always_comb begin
      code_in  = code_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      atom_in  = atom_ff;
      has_in   = has_ff;
      end_in   = end_ff;
      s_in     = s_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      big_in   = big_ff;
      it_in    = it_ff;
      z_in     = z_ff;
      n_in     = n_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      elem_in  = elem_ff;
      rv_in    = rsp_stall ? rv_ff : 1'b0;
      kind_in  = kind_ff;
      val_in   = val_ff;
      cause_in = cause_ff;
      last_in  = last_ff;
      if (go) begin
         unique case (ctrl.op)
            OP_NOP: begin
            end
            OP_LATCH: begin
               atom_in = req_atom_value;
               has_in  = req_has_atom;
               end_in  = req_list_end;
               z_in    = req_packed_code[31:3];
               n_in    = req_packed_code[2:0];
            end
            OP_ATOM: begin
               if (cnt_ff >= CNT_W'(MAX_ATOMS)) begin
                  cnt_in = CNT_W'(MAX_ATOMS + 1);
               end else if (cnt_ff == '0) begin
                  code_in = L'(atom_ff);
                  if (SW'(atom_ff) > SW'(LIMIT)) begin
                     ovf_in = 1'b1;
                  end
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  if (!ovf_ff && (sum > SW'(LIMIT))) begin
                     ovf_in = 1'b1;
                  end
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               s_in   = sum[L-1:0];
               sh_in  = sum[L-1:0];
               acc_in = '0;
               big_in = 1'b0;
               it_in  = IT_W'(L - 1);
            end
            OP_MUL: begin
               // MSB-first shift-add of s*(s+1); flag overflow once past 2*limit
               if (mul_nxt[L+2:L+1] != 2'b00) begin
                  big_in = 1'b1;
               end
               acc_in = mul_nxt[L:0];
               sh_in  = {sh_ff[L-2:0], 1'b0};
               it_in  = it_ff - IT_W'(1);
            end
            OP_FOLD: begin
               if (big_ff || zsum[L]) begin
                  ovf_in = 1'b1;
               end else begin
                  code_in = zsum[L-1:0];
               end
            end
            OP_EMIT_ENC: begin
               rv_in   = 1'b1;
               last_in = 1'b1;
               if (cnt_ff > CNT_W'(MAX_ATOMS)) begin
                  kind_in  = KIND_ERROR;
                  val_in   = '0;
                  cause_in = CAUSE_TOO_MANY;
               end else if (ovf_ff) begin
                  kind_in  = KIND_ERROR;
                  val_in   = '0;
                  cause_in = CAUSE_OVERFLOW;
               end else if (cnt_ff == '0) begin
                  kind_in  = KIND_CODE;
                  val_in   = '0;
                  cause_in = CAUSE_NONE;
               end else begin
                  kind_in  = KIND_CODE;
                  val_in   = enc_ext[31:0];
                  cause_in = CAUSE_NONE;
               end
               code_in = '0;
               cnt_in  = '0;
               ovf_in  = 1'b0;
            end
            OP_SQ_INIT: begin
               v_in   = {z_ff, 3'b001};
               r_in   = '0;
               rem_in = '0;
               it_in  = IT_W'(15);
            end
            OP_SQ_STEP: begin
               // one root digit per step
               if (remc >= trial) begin
                  rem_in = 18'(remc - trial);
                  r_in   = {r_ff[14:0], 1'b1};
               end else begin
                  rem_in = remc[17:0];
                  r_in   = {r_ff[14:0], 1'b0};
               end
               v_in  = {v_ff[29:0], 2'b00};
               it_in = it_ff - IT_W'(1);
            end
            OP_TRI: begin
               prod_in = 31'(w) * 31'(wp1);
            end
            OP_PEEL: begin
               elem_in = 16'(w - xs[14:0]);
               z_in    = xs[DEC_Z_W-1:0];
               n_in    = n_ff - 3'd1;
            end
            OP_EMIT_ATOM: begin
               rv_in    = 1'b1;
               kind_in  = KIND_ATOM;
               val_in   = 32'(elem_ff);
               cause_in = CAUSE_NONE;
               last_in  = 1'b0;
            end
            OP_EMIT_LAST: begin
               rv_in    = 1'b1;
               kind_in  = KIND_ATOM;
               val_in   = 32'(z_ff);
               cause_in = CAUSE_NONE;
               last_in  = 1'b1;
            end
            OP_EMIT_EMPTY: begin
               rv_in    = 1'b1;
               kind_in  = KIND_EMPTY;
               val_in   = '0;
               cause_in = CAUSE_NONE;
               last_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         code_ff <= code_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      atom_ff  <= atom_in;
      has_ff   <= has_in;
      end_ff   <= end_in;
      s_ff     <= s_in;
      sh_ff    <= sh_in;
      acc_ff   <= acc_in;
      big_ff   <= big_in;
      it_ff    <= it_in;
      z_ff     <= z_in;
      n_ff     <= n_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      elem_ff  <= elem_in;
      kind_ff  <= kind_in;
      val_ff   <= val_in;
      cause_ff <= cause_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_value       = val_ff;
   assign rsp_error_cause = cause_ff;
   assign rsp_last_result = last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ATOMS + 1))
      else $error("atom count beyond saturation");

   a_enc_clear: assert property (@(posedge clock) disable iff (reset)
      (go && ctrl.op == OP_EMIT_ENC) |=> (cnt_ff == '0) && !ovf_ff)
      else $error("list state not cleared after list end");

   a_peel_count: assert property (@(posedge clock) disable iff (reset)
      (go && ctrl.op == OP_PEEL) |-> (n_ff > 3'd1))
      else $error("peel with no element left");

   a_peel_range: assert property (@(posedge clock) disable iff (reset)
      (go && ctrl.op == OP_PEEL) |-> (tri_w <= 30'(z_ff)))
      else $error("triangular number exceeds remaining code");

endmodule

FILE: design/pairing_list_codec_core.sv
// Top level of the pairing list codec: sequencer plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  operation, atom_value, has_atom,
//                                              list_end, packed_code
//   rsp      out        rsp_valid / rsp_stall  kind, value, error_cause,
//                                              last_result
//
// One request at a time. Encode latches the request, adds its atom to the list state
// and emits the code on list end; an atom that folds in also runs the bit-serial
// multiplier. Decode peels each atom but the last with a 16-step square root and a
// triangular product, emitting each atom in turn; count zero emits an empty result.
// Synchronous reset clears the list state and the result valid flag.
// A stalled result holds the sequencer in its emit step.
`timescale 1ns / 1ps

module pairing_list_codec_core #(
   parameter int MAX_ATOMS = plc_pkg::MAX_ATOMS_DEF,
   parameter int CODE_BITS = plc_pkg::CODE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_atom_value,
   input  logic        req_has_atom,
   input  logic        req_list_end,
   input  logic [31:0] req_packed_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_error_cause,
   output logic        rsp_last_result
);
   import plc_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   logic       idle;

   assign req_stall = !idle;

   plc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl),
      .idle      (idle)
   );

   plc_datapath #(
      .MAX_ATOMS (MAX_ATOMS),
      .CODE_BITS (CODE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_operation   (req_operation),
      .req_atom_value  (req_atom_value),
      .req_has_atom    (req_has_atom),
      .req_list_end    (req_list_end),
      .req_packed_code (req_packed_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_error_cause (rsp_error_cause),
      .rsp_last_result (rsp_last_result)
   );

endmodule
